/* rtl/seglcd_pkg.sv */
// Shared types, codes and the segment encoding table for the segment LCD frame builder.
// No dependencies; every other file but the checker imports this package.
package seglcd_pkg;

    localparam int POS_W    = 4;
    localparam int DIGIT_W  = 8;
    localparam int NUM_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int BIN_BITS = 14;
    localparam int BCD_W    = 16;
    localparam int CNT_W    = 4;

    localparam logic [NUM_W-1:0] MAX_VALUE = 16'd9999;

    localparam logic [1:0] ACT_PRINT_VALUE = 2'd0;
    localparam logic [1:0] ACT_PRINT_DIGIT = 2'd1;
    localparam logic [1:0] ACT_CLEAR       = 2'd2;
    localparam logic [1:0] ACT_ALL_ON      = 2'd3;

    localparam logic [1:0] REG_THOUSANDS = 2'd0;
    localparam logic [1:0] REG_HUNDREDS  = 2'd1;
    localparam logic [1:0] REG_TENS      = 2'd2;
    localparam logic [1:0] REG_UNITS     = 2'd3;

    localparam logic [POS_W-1:0] RST_THOUSANDS = 4'd4;
    localparam logic [POS_W-1:0] RST_HUNDREDS  = 4'd3;
    localparam logic [POS_W-1:0] RST_TENS      = 4'd2;
    localparam logic [POS_W-1:0] RST_UNITS     = 4'd1;

    localparam logic [BYTE_W-1:0] FILL_OFF  = 8'h00;
    localparam logic [BYTE_W-1:0] FILL_ON   = 8'hFF;
    localparam logic [BYTE_W-1:0] SPILL_BIT = 8'h01;
    localparam logic [BYTE_W-1:0] CODE_MASK = 8'hFE;

    typedef struct packed {
        logic [POS_W-1:0] thousands;
        logic [POS_W-1:0] hundreds;
        logic [POS_W-1:0] tens;
        logic [POS_W-1:0] units;
    } positions_t;

    // Segment code for one digit; table picked by position parity, non-digits blank.
    function automatic logic [BYTE_W-1:0] seg_encode(input logic [DIGIT_W-1:0] d,
                                                     input logic odd);
        logic [BYTE_W-1:0] code;
        code = FILL_OFF;
        if (odd)
        begin
            case (d)
                8'd0: code = 8'hBD;
                8'd1: code = 8'h0C;
                8'd2: code = 8'h75;
                8'd3: code = 8'h5D;
                8'd4: code = 8'hCC;
                8'd5: code = 8'hD9;
                8'd6: code = 8'hF9;
                8'd7: code = 8'h0D;
                8'd8: code = 8'hFD;
                8'd9: code = 8'hDD;
                default: code = FILL_OFF;
            endcase
        end
        else
        begin
            case (d)
                8'd0: code = 8'hDE;
                8'd1: code = 8'h06;
                8'd2: code = 8'hBA;
                8'd3: code = 8'hAE;
                8'd4: code = 8'h66;
                8'd5: code = 8'hEC;
                8'd6: code = 8'hFC;
                8'd7: code = 8'h86;
                8'd8: code = 8'hFE;
                8'd9: code = 8'hEE;
                default: code = FILL_OFF;
            endcase
        end
        return code;
    endfunction

endpackage

/* rtl/seglcd_regs.sv */
// APB-style configuration registers: the four digit positions.
// Depends on seglcd_pkg.
module seglcd_regs
    import seglcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output positions_t  positions
);

    positions_t pos_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg.thousands <= RST_THOUSANDS;
            pos_reg.hundreds  <= RST_HUNDREDS;
            pos_reg.tens      <= RST_TENS;
            pos_reg.units     <= RST_UNITS;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_THOUSANDS: pos_reg.thousands <= pwdata[POS_W-1:0];
                REG_HUNDREDS:  pos_reg.hundreds  <= pwdata[POS_W-1:0];
                REG_TENS:      pos_reg.tens      <= pwdata[POS_W-1:0];
                REG_UNITS:     pos_reg.units     <= pwdata[POS_W-1:0];
                default:       pos_reg.units     <= pos_reg.units;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_THOUSANDS: prdata = {28'd0, pos_reg.thousands};
            REG_HUNDREDS:  prdata = {28'd0, pos_reg.hundreds};
            REG_TENS:      prdata = {28'd0, pos_reg.tens};
            REG_UNITS:     prdata = {28'd0, pos_reg.units};
            default:       prdata = 32'd0;
        endcase
    end

    assign positions = pos_reg;

endmodule

/* rtl/seglcd_bcd.sv */
// Binary to BCD converter: one decimal digit per cycle by parallel compare and subtract,
// thousands first; the remainder left after the tens step is the units digit.
// Depends on seglcd_pkg.
module seglcd_bcd
    import seglcd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [BIN_BITS-1:0] value,
    output logic                done,
    output logic [BCD_W-1:0]    bcd
);

    localparam logic [CNT_W-1:0] STEPS = CNT_W'(3);

    logic [BIN_BITS-1:0] rem_reg;
    logic [BIN_BITS-1:0] rem_next;
    logic [BIN_BITS-1:0] rem_left;
    logic [BIN_BITS-1:0] mult;
    logic [BCD_W-1:0]    bcd_reg;
    logic [BCD_W-1:0]    bcd_next;
    logic [3:0]          dig;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                done_reg;
    logic                done_next;

    // Largest multiple of the current weight that fits in the remainder.
    always_comb
    begin
        dig      = 4'd0;
        rem_left = rem_reg;
        mult     = '0;
        for (int k = 1; k < 10; k++)
        begin
            case (cnt_reg)
                CNT_W'(3): mult = BIN_BITS'(k * 1000);
                CNT_W'(2): mult = BIN_BITS'(k * 100);
                default:   mult = BIN_BITS'(k * 10);
            endcase
            if (rem_reg >= mult)
            begin
                dig      = 4'(k);
                rem_left = rem_reg - mult;
            end
        end
    end

    always_comb
    begin
        rem_next  = rem_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = value;
            bcd_next = '0;
            cnt_next = STEPS;
        end
        else if (cnt_reg != '0)
        begin
            rem_next = rem_left;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                // tens step: append the tens digit and the units left over
                bcd_next  = {bcd_reg[BCD_W-9:0], dig, rem_left[3:0]};
                done_next = 1'b1;
            end
            else
            begin
                bcd_next = {bcd_reg[BCD_W-5:0], dig};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

/* rtl/seglcd_frame_mem.sv */
// Frame store: one write port, one synchronous read port, per-entry valid bits.
// An entry never written reads as zero. Depends on seglcd_pkg.
module seglcd_frame_mem
    import seglcd_pkg::*;
#(
    parameter int DEPTH = 11,
    parameter int AW    = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [BYTE_W-1:0] rdata_reg;
    logic              rvld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rvld_reg  <= 1'b0;
        end
        else
        begin
            if (we)
                valid_reg[waddr] <= 1'b1;
            rvld_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvld_reg ? rdata_reg : FILL_OFF;

endmodule

/* rtl/segment_lcd_frame_builder.sv */
// Segment LCD frame builder. Clear/all-on go straight to the frame output; print digit
// first does the frame read-modify-write, print value a BCD conversion and then the frame
// read-modify-write for each digit. FRAME_BYTES bytes follow, one per cycle; busy drops as
// the last one goes out, and no new item is taken before that. A value above 9999 is dropped
// at accept. Reset (rst_n, async) clears the frame and loads digit positions 4, 3, 2, 1.
// Results cannot be stalled.
module segment_lcd_frame_builder
    import seglcd_pkg::*;
#(
    parameter int FRAME_BYTES = 11
)
(
    input  logic               clk,
    input  logic               rst_n,
    // item transfer
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [NUM_W-1:0]   number,
    input  logic [DIGIT_W-1:0] digit,
    input  logic [POS_W-1:0]   position,
    // result transfer, one byte per strobe
    output logic               result_valid,
    output logic [BYTE_W-1:0]  frame_byte,
    output logic               last_byte,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_BYTES - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BCD   = 3'd1;
    localparam logic [2:0] S_PUT   = 3'd2;
    localparam logic [2:0] S_SPILL = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         act_reg, act_next;
    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [1:0]         dsel_reg, dsel_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               fill_mode_reg, fill_mode_next;
    logic [BYTE_W-1:0]  fill_reg, fill_next;
    logic               rv_reg, rv_next;
    logic               last_reg, last_next;

    positions_t         positions;
    logic               accept;
    logic               bcd_start;
    logic               bcd_done;
    logic [BCD_W-1:0]   bcd;

    logic [DIGIT_W-1:0] cur_digit;
    logic [POS_W-1:0]   cur_pos;
    logic [BYTE_W-1:0]  code;
    logic               in_frame;
    logic               spill_need;
    logic [AW-1:0]      cur_addr;
    logic [AW-1:0]      prev_addr;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [BYTE_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [BYTE_W-1:0]  mem_rdata;

    seglcd_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .positions (positions)
    );

    seglcd_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start),
        .value (number[BIN_BITS-1:0]),
        .done  (bcd_done),
        .bcd   (bcd)
    );

    seglcd_frame_mem #(
        .DEPTH (FRAME_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign pready = 1'b1;
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Pick the digit and position being written: the single digit of a print-digit
    // item, or the BCD digit named by dsel_reg, thousands first.
    always_comb
    begin
        if (act_reg == ACT_PRINT_DIGIT)
        begin
            cur_digit = digit_reg;
            cur_pos   = pos_reg;
        end
        else
        begin
            case (dsel_reg)
                2'd0:
                begin
                    cur_digit = {4'd0, bcd[15:12]};
                    cur_pos   = positions.thousands;
                end
                2'd1:
                begin
                    cur_digit = {4'd0, bcd[11:8]};
                    cur_pos   = positions.hundreds;
                end
                2'd2:
                begin
                    cur_digit = {4'd0, bcd[7:4]};
                    cur_pos   = positions.tens;
                end
                default:
                begin
                    cur_digit = {4'd0, bcd[3:0]};
                    cur_pos   = positions.units;
                end
            endcase
        end
    end

    // Parity selects the table even when the position lies outside the frame.
    assign code       = seg_encode(cur_digit, cur_pos[0]);
    assign in_frame   = (32'(cur_pos) < FRAME_BYTES);
    assign spill_need = code[0] && (cur_pos != '0) && in_frame;
    assign cur_addr   = AW'(cur_pos);
    assign prev_addr  = cur_addr - AW'(1);

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        digit_next     = digit_reg;
        pos_next       = pos_reg;
        dsel_next      = dsel_reg;
        idx_next       = idx_reg;
        fill_mode_next = fill_mode_reg;
        fill_next      = fill_reg;
        rv_next        = 1'b0;
        last_next      = 1'b0;
        bcd_start      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = cur_addr;
        mem_wdata      = code & CODE_MASK;
        mem_raddr      = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next   = action;
                    digit_next = digit;
                    pos_next   = position;
                    dsel_next  = 2'd0;
                    idx_next   = '0;
                    case (action)
                        ACT_PRINT_VALUE:
                        begin
                            // drop values that do not fit four digits
                            if (number <= MAX_VALUE)
                            begin
                                bcd_start  = 1'b1;
                                state_next = S_BCD;
                            end
                        end
                        ACT_PRINT_DIGIT:
                        begin
                            state_next = S_PUT;
                        end
                        ACT_CLEAR:
                        begin
                            fill_mode_next = 1'b1;
                            fill_next      = FILL_OFF;
                            state_next     = S_EMIT;
                        end
                        default:
                        begin
                            fill_mode_next = 1'b1;
                            fill_next      = FILL_ON;
                            state_next     = S_EMIT;
                        end
                    endcase
                end
            end

            S_BCD:
            begin
                if (bcd_done)
                    state_next = S_PUT;
            end

            S_PUT:
            begin
                // Write the cleared code at the position if it lies in the frame and fetch the byte before it;
                // the two addresses differ, so the order of write and spill is free.
                mem_we    = in_frame;
                mem_raddr = prev_addr;
                if (spill_need)
                begin
                    state_next = S_SPILL;
                end
                else if ((act_reg == ACT_PRINT_DIGIT) || (dsel_reg == 2'd3))
                begin
                    fill_mode_next = 1'b0;
                    state_next     = S_EMIT;
                end
                else
                begin
                    dsel_next = dsel_reg + 2'd1;
                end
            end

            S_SPILL:
            begin
                // OR the segment bit into the previous byte
                mem_we    = 1'b1;
                mem_waddr = prev_addr;
                mem_wdata = mem_rdata | SPILL_BIT;
                if ((act_reg == ACT_PRINT_DIGIT) || (dsel_reg == 2'd3))
                begin
                    fill_mode_next = 1'b0;
                    state_next     = S_EMIT;
                end
                else
                begin
                    dsel_next  = dsel_reg + 2'd1;
                    state_next = S_PUT;
                end
            end

            S_EMIT:
            begin
                // Issue one read per cycle; the byte shows the cycle after.
                rv_next   = 1'b1;
                last_next = (idx_reg == LAST_IDX);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= ACT_PRINT_VALUE;
            dsel_reg      <= 2'd0;
            idx_reg       <= '0;
            fill_mode_reg <= 1'b0;
            rv_reg        <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            dsel_reg      <= dsel_next;
            idx_reg       <= idx_next;
            fill_mode_reg <= fill_mode_next;
            rv_reg        <= rv_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        pos_reg   <= pos_next;
        fill_reg  <= fill_next;
    end

    assign result_valid = rv_reg;
    assign last_byte    = last_reg;
    assign frame_byte   = fill_mode_reg ? fill_reg : mem_rdata;

endmodule

/* rtl/seglcd_checker.sv */
// Port-level checker for the segment LCD frame builder, bound to the top level.
// Depends only on the top level's ports.
module seglcd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_valid,
    input logic       last_byte,
    input logic [7:0] frame_byte
);

    // A frame end marker only rides on a delivered byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        last_byte |-> result_valid)
        else $error("last_byte without result_valid");

    // Bytes of one frame come back to back until the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_byte) |=> result_valid)
        else $error("gap inside a frame");

    // While a frame is still going out, no new item may be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_byte) |-> busy)
        else $error("block idle in the middle of a frame");

    // A frame never starts without prior work.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(busy))
        else $error("frame started without a busy period");

    // Every delivered byte carries a known value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !$isunknown(frame_byte))
        else $error("unknown frame byte delivered");

endmodule

bind segment_lcd_frame_builder seglcd_checker u_seglcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .last_byte    (last_byte),
    .frame_byte   (frame_byte)
);

/* test/seglcd_frame_tracker_pkg.sv */
// Frame tracker for the segment LCD frame builder bench: shadow frame, digit positions
// and the queue of frame bytes still due. Depends on seglcd_pkg for widths and codes.
`timescale 1ns / 1ps
package seglcd_frame_tracker_pkg;
    import seglcd_pkg::*;

    localparam int FRAME_LEN = 11;

    // Segment codes, digit 0 in the low byte; one table per position parity.
    localparam logic [10*BYTE_W-1:0] EVEN_SEGS =
        {8'hEE, 8'hFE, 8'h86, 8'hFC, 8'hEC, 8'h66, 8'hAE, 8'hBA, 8'h06, 8'hDE};
    localparam logic [10*BYTE_W-1:0] ODD_SEGS =
        {8'hDD, 8'hFD, 8'h0D, 8'hF9, 8'hD9, 8'hCC, 8'h5D, 8'h75, 8'h0C, 8'hBD};

    typedef struct packed {
        logic [BYTE_W-1:0] seg;
        logic              last;
    } lcd_byte_t;

    class frame_tracker;
        logic [BYTE_W-1:0] shadow_frame [FRAME_LEN];
        positions_t        digit_pos;
        lcd_byte_t         bytes_due [$];
        int                mismatches;

        function new();
            foreach (shadow_frame[i])
                shadow_frame[i] = FILL_OFF;
            digit_pos.thousands = RST_THOUSANDS;
            digit_pos.hundreds  = RST_HUNDREDS;
            digit_pos.tens      = RST_TENS;
            digit_pos.units     = RST_UNITS;
            mismatches = 0;
        endfunction

        function void set_position(logic [1:0] which, logic [POS_W-1:0] value);
            case (which)
                REG_THOUSANDS: digit_pos.thousands = value;
                REG_HUNDREDS:  digit_pos.hundreds  = value;
                REG_TENS:      digit_pos.tens      = value;
                REG_UNITS:     digit_pos.units     = value;
                default:       digit_pos.units     = digit_pos.units;
            endcase
        endfunction

        function logic [BYTE_W-1:0] segment_code(int d, logic [POS_W-1:0] pos);
            if (d > 9)
                return FILL_OFF;
            return pos[0] ? ODD_SEGS[d*BYTE_W +: BYTE_W] : EVEN_SEGS[d*BYTE_W +: BYTE_W];
        endfunction

        // Parity picks the table even when the write itself falls off the frame.
        function void write_digit(int d, logic [POS_W-1:0] pos);
            logic [BYTE_W-1:0] code;
            code = segment_code(d, pos);
            if (pos >= FRAME_LEN)
                return;
            if (code[0])
            begin
                code[0] = 1'b0;
                if (pos != 0)
                    shadow_frame[pos - 1][0] = 1'b1;
            end
            shadow_frame[pos] = code;
        endfunction

        function void queue_frame(bit from_shadow, logic [BYTE_W-1:0] fill);
            lcd_byte_t b;
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                b.seg  = from_shadow ? shadow_frame[i] : fill;
                b.last = (i == FRAME_LEN - 1);
                bytes_due.push_back(b);
            end
        endfunction

        // Note one accepted command and queue the frame it produces.
        function void accept_command(logic [1:0] act, logic [NUM_W-1:0] num,
                                     logic [DIGIT_W-1:0] dig, logic [POS_W-1:0] pos);
            case (act)
                ACT_PRINT_VALUE:
                begin
                    if (num > MAX_VALUE)
                        return;
                    write_digit(int'(num) / 1000, digit_pos.thousands);
                    write_digit((int'(num) / 100) % 10, digit_pos.hundreds);
                    write_digit((int'(num) / 10) % 10, digit_pos.tens);
                    write_digit(int'(num) % 10, digit_pos.units);
                    queue_frame(1'b1, FILL_OFF);
                end
                ACT_PRINT_DIGIT:
                begin
                    write_digit(int'(dig), pos);
                    queue_frame(1'b1, FILL_OFF);
                end
                ACT_CLEAR:  queue_frame(1'b0, FILL_OFF);
                default:    queue_frame(1'b0, FILL_ON);
            endcase
        endfunction

        function void check_byte(logic [BYTE_W-1:0] seg, logic last);
            lcd_byte_t want;
            if (bytes_due.size() == 0)
            begin
                $error("frame_byte 0x%02h (last_byte %0b) arrived with no frame pending",
                       seg, last);
                mismatches++;
                return;
            end
            want = bytes_due.pop_front();
            if (seg !== want.seg)
            begin
                $error("frame_byte mismatch: expected 0x%02h, got 0x%02h", want.seg, seg);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("last_byte mismatch: expected %0b, got %0b", want.last, last);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return bytes_due.size();
        endfunction
    endclass

endpackage

/* test/tb_segment_lcd_frame_builder.sv */
// Top-level bench for segment_lcd_frame_builder: drives commands and APB position writes,
// checks every emitted frame byte against seglcd_frame_tracker_pkg.
// Depends on seglcd_pkg and seglcd_frame_tracker_pkg.
`timescale 1ns / 1ps
module tb_segment_lcd_frame_builder;
    import seglcd_pkg::*;
    import seglcd_frame_tracker_pkg::*;

    // Longest print value latency plus one frame, with some margin.
    localparam int SETTLE_CYCLES   = 48;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 85;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         action;
    logic [NUM_W-1:0]   number;
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   position;
    logic               result_valid;
    logic [BYTE_W-1:0]  frame_byte;
    logic               last_byte;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    frame_tracker tracker;

    segment_lcd_frame_builder #(
        .FRAME_BYTES (FRAME_LEN)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .number       (number),
        .digit        (digit),
        .position     (position),
        .result_valid (result_valid),
        .frame_byte   (frame_byte),
        .last_byte    (last_byte),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // Check every byte transfer. Values read right after the edge are the ones
    // the edge sampled, since the block updates them in the NBA region.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            tracker.check_byte(frame_byte, last_byte);
    end

    // Present a command and hold it until the block takes it. Leave start high
    // so a back-to-back command needs no second assignment in this step.
    task automatic send_item(logic [1:0] act, logic [NUM_W-1:0] num,
                             logic [DIGIT_W-1:0] dig, logic [POS_W-1:0] pos);
        start    <= 1'b1;
        action   <= act;
        number   <= num;
        digit    <= dig;
        position <= pos;
        do
            @(posedge clk);
        while (busy);
        tracker.accept_command(act, num, dig, pos);
    endtask

    // Drop start for a burst and scramble the idle fields meanwhile.
    task automatic idle_for(int cycles);
        start    <= 1'b0;
        action   <= 2'($urandom);
        number   <= 16'($urandom);
        digit    <= 8'($urandom);
        position <= 4'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    // Hold off until every frame has come out, then let the block settle.
    // Dropped values leave nothing queued, so the settle time covers them.
    task automatic drain_frames();
        start <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access until pready.
    task automatic write_position(logic [1:0] which, logic [POS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= {28'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_position(which, value);
    endtask

    task automatic apply_positions(logic [POS_W-1:0] th, logic [POS_W-1:0] hu,
                                   logic [POS_W-1:0] te, logic [POS_W-1:0] un);
        write_position(REG_THOUSANDS, th);
        write_position(REG_HUNDREDS, hu);
        write_position(REG_TENS, te);
        write_position(REG_UNITS, un);
    endtask

    initial
    begin
        int                 counted;
        bit                 paused;
        logic [1:0]         act;
        logic [NUM_W-1:0]   num;
        logic [DIGIT_W-1:0] dig;
        logic [POS_W-1:0]   pos;

        tracker  = new();
        paused   = 1'b0;
        rst_n    <= 1'b0;
        start    <= 1'b0;
        action   <= ACT_CLEAR;
        number   <= '0;
        digit    <= '0;
        position <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: value extremes, values too large, every digit once with the parities
        // alternating, non-digits, positions at and past the frame end, fills.
        send_item(ACT_PRINT_VALUE, 16'd0, 8'($urandom), 4'($urandom));
        send_item(ACT_PRINT_VALUE, MAX_VALUE, 8'($urandom), 4'($urandom));
        send_item(ACT_PRINT_VALUE, 16'd10000, 8'd3, 4'd2);
        send_item(ACT_PRINT_VALUE, 16'hFFFF, 8'd5, 4'd7);
        send_item(ACT_PRINT_VALUE, 16'd1234, 8'($urandom), 4'($urandom));
        send_item(ACT_PRINT_VALUE, 16'd8080, 8'($urandom), 4'($urandom));
        for (int d = 0; d < 10; d++)
            send_item(ACT_PRINT_DIGIT, 16'($urandom), 8'(d), 4'(9 - d));
        send_item(ACT_PRINT_DIGIT, 16'($urandom), 8'd10, 4'd5);
        send_item(ACT_PRINT_DIGIT, 16'($urandom), 8'd255, 4'd10);
        send_item(ACT_PRINT_DIGIT, 16'($urandom), 8'd8, 4'd11);
        send_item(ACT_PRINT_DIGIT, 16'($urandom), 8'd3, 4'd15);
        send_item(ACT_PRINT_DIGIT, 16'($urandom), 8'd7, 4'd0);
        send_item(ACT_CLEAR, 16'($urandom), 8'($urandom), 4'($urandom));
        send_item(ACT_ALL_ON, 16'($urandom), 8'($urandom), 4'($urandom));

        // Random phases, each under its own digit layout. The last phase runs
        // with no gaps at all.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain_frames();
                case (ph)
                    1: apply_positions(4'd0, 4'd0, 4'd0, 4'd0);
                    2: apply_positions(4'd10, 4'd10, 4'd10, 4'd10);
                    3: apply_positions(4'd7, 4'd10, 4'd0, 4'd5);
                    default: apply_positions(4'($urandom_range(0, 10)),
                                             4'($urandom_range(0, 10)),
                                             4'($urandom_range(0, 10)),
                                             4'($urandom_range(0, 10)));
                endcase
            end
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                act = 2'($urandom);
                num = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 9999));
                dig = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, 9));
                pos = 4'($urandom_range(0, 10));
                send_item(act, num, dig, pos);
                // Values too large are ignored by the block; don't count them.
                if (!(act == ACT_PRINT_VALUE && num > MAX_VALUE))
                    counted++;
                if (ph == 1 && !paused && counted == ITEMS_PER_PHASE / 2)
                begin
                    paused = 1'b1;
                    drain_frames();
                end
                else if (ph != PHASES - 1 && $urandom_range(0, 3) == 0)
                    idle_for($urandom_range(1, 10));
            end
        end

        drain_frames();
        if (tracker.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
